// ----- design/dtg_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// DTMF tone generator package
// Shared constants, types, tone increments and the quarter-wave sine table.
// ============================================================================
package dtg_pkg;

    // Build-time configuration
    localparam int unsigned SAMPLE_RATE     = 44100;
    localparam int unsigned QUEUE_DEPTH     = 16;
    localparam int unsigned SINE_TABLE_BITS = 10;

    // Derived sizes
    localparam int unsigned PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned LEVEL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int unsigned QUARTER      = 1 << QUARTER_BITS;

    // Field and register widths
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned SINE_W   = 16;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned AMP_W    = 14;
    localparam int unsigned LEN_W    = 20;
    localparam int unsigned SYM_W    = 4;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    // Register reset values
    localparam logic [AMP_W-1:0] AMPLITUDE_RST = AMP_W'(8000);
    localparam logic [LEN_W-1:0] TONE_RST      = LEN_W'(4410);
    localparam logic [LEN_W-1:0] PAUSE_RST     = LEN_W'(4410);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_AMPLITUDE     = 2'd0,
        CFG_TONE_SAMPLES  = 2'd1,
        CFG_PAUSE_SAMPLES = 2'd2
    } cfg_idx_t;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Playback state, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TONE  = 3'b010,
        MODE_PAUSE = 3'b100
    } play_mode_t;

    // Control into the digit queue
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [SYM_W-1:0] symbol;
    } queue_ctrl_t;

    // Status out of the digit queue
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level_next;
    } queue_stat_t;

    // Control into the tone synthesiser
    typedef struct packed {
        logic             run;
        logic             restart;
        logic [SYM_W-1:0] digit;
    } tone_ctrl_t;

    // Tone frequencies in Hz
    localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

    typedef logic [PHASE_W-1:0] inc_tab_t [4];
    typedef logic [MAG_W-1:0]   qsine_tab_t [QUARTER];

    // Rounded phase step for one tone, evaluated at elaboration only
    function automatic logic [PHASE_W-1:0] phase_inc(input int unsigned hz);
        logic [63:0] num;
        num = (64'(hz) << 32) + 64'(SAMPLE_RATE / 2);
        return PHASE_W'(num / 64'(SAMPLE_RATE));
    endfunction

    function automatic inc_tab_t build_row_inc();
        inc_tab_t tab;
        for (int i = 0; i < 4; i++)
        begin
            tab[i] = phase_inc(ROW_HZ[i]);
        end
        return tab;
    endfunction

    function automatic inc_tab_t build_col_inc();
        inc_tab_t tab;
        for (int i = 0; i < 4; i++)
        begin
            tab[i] = phase_inc(COL_HZ[i]);
        end
        return tab;
    endfunction

    // Polynomial quarter sine in Q14, elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] r;
        z  = 64'(k) << (18 - SINE_TABLE_BITS);
        z2 = (z * z) >> 16;
        t  = (64'd307 * z2) >> 16;
        t  = 64'd5223 - t;
        t  = (t * z2) >> 16;
        t  = 64'd42334 - t;
        t  = (t * z2) >> 16;
        t  = 64'd102944 - t;
        r  = (t * z) >> 16;
        r  = (r + 64'd2) >> 2;
        if (r > 64'd16384)
        begin
            r = 64'd16384;
        end
        return MAG_W'(r);
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        for (int i = 0; i < int'(QUARTER); i++)
        begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    localparam inc_tab_t   ROW_INC    = build_row_inc();
    localparam inc_tab_t   COL_INC    = build_col_inc();
    localparam qsine_tab_t QSINE      = build_qsine();
    localparam logic [MAG_W-1:0] QSINE_PEAK = quarter_sine(QUARTER);

endpackage

// ----- design/dtg_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// DTMF digit queue
// Circular FIFO of pending symbols with occupancy count and head read-out.
// ============================================================================
module dtg_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dtg_pkg::queue_ctrl_t         ctrl,
    output dtg_pkg::queue_stat_t         stat,
    output logic [dtg_pkg::SYM_W-1:0]    head
);

    logic [dtg_pkg::SYM_W-1:0]   mem [dtg_pkg::QUEUE_DEPTH];
    logic [dtg_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [dtg_pkg::PTR_W-1:0]   rd_ptr_next;
    logic [dtg_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [dtg_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [dtg_pkg::LEVEL_W-1:0] count_reg;
    logic [dtg_pkg::LEVEL_W-1:0] count_next;

    // Pointer wrap and occupancy
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == dtg_pkg::PTR_W'(dtg_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dtg_pkg::PTR_W'(dtg_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Symbol storage
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= ctrl.symbol;
        end
    end

    assign head            = mem[rd_ptr_reg];
    assign stat.full       = (count_reg == dtg_pkg::LEVEL_W'(dtg_pkg::QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.level_next = count_next;

endmodule

// ----- design/dtg_tone.sv -----
`timescale 1ns / 1ps
// ============================================================================
// DTMF dual-tone synthesiser
// Row and column phase accumulators, sine look-up and scaled, saturated mix.
// ============================================================================
module dtg_tone
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtg_pkg::tone_ctrl_t                 ctrl,
    input  logic [dtg_pkg::AMP_W-1:0]           amplitude,
    output logic signed [dtg_pkg::SAMPLE_W-1:0] sample
);

    logic [dtg_pkg::PHASE_W-1:0] row_phase_reg;
    logic [dtg_pkg::PHASE_W-1:0] row_phase_next;
    logic [dtg_pkg::PHASE_W-1:0] col_phase_reg;
    logic [dtg_pkg::PHASE_W-1:0] col_phase_next;

    logic signed [dtg_pkg::SINE_W-1:0] row_sine;
    logic signed [dtg_pkg::SINE_W-1:0] col_sine;
    logic signed [dtg_pkg::SINE_W:0]   sine_sum;
    logic signed [31:0]                product;
    logic signed [31:0]                rounded;
    logic signed [17:0]                scaled;
    logic signed [dtg_pkg::SAMPLE_W-1:0] clipped;

    // Full-wave sine from the quarter table by quadrant symmetry
    function automatic logic signed [dtg_pkg::SINE_W-1:0] sine_lookup(
        input logic [dtg_pkg::SINE_TABLE_BITS-1:0] idx
    );
        logic [dtg_pkg::QUARTER_BITS-1:0] j;
        logic [dtg_pkg::QUARTER_BITS-1:0] jm;
        logic [dtg_pkg::MAG_W-1:0]        mag;
        logic signed [dtg_pkg::SINE_W-1:0] val;
        j  = idx[dtg_pkg::QUARTER_BITS-1:0];
        jm = ~j;
        jm = jm + 1'b1;
        if (idx[dtg_pkg::SINE_TABLE_BITS-2])
        begin
            mag = (j == '0) ? dtg_pkg::QSINE_PEAK : dtg_pkg::QSINE[jm];
        end
        else
        begin
            mag = dtg_pkg::QSINE[j];
        end
        val = $signed({1'b0, mag});
        if (idx[dtg_pkg::SINE_TABLE_BITS-1])
        begin
            val = -val;
        end
        return val;
    endfunction

    // Phase advance; a new digit starts both phases from zero
    always_comb
    begin
        row_phase_next = (ctrl.restart ? '0 : row_phase_reg)
                       + dtg_pkg::ROW_INC[ctrl.digit[3:2]];
        col_phase_next = (ctrl.restart ? '0 : col_phase_reg)
                       + dtg_pkg::COL_INC[ctrl.digit[1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_phase_reg <= '0;
            col_phase_reg <= '0;
        end
        else if (ctrl.run)
        begin
            row_phase_reg <= row_phase_next;
            col_phase_reg <= col_phase_next;
        end
    end

    // Mix: amplitude * (row + column), round half up, saturate
    always_comb
    begin
        row_sine = sine_lookup(row_phase_reg[dtg_pkg::PHASE_W-1 -: dtg_pkg::SINE_TABLE_BITS]);
        col_sine = sine_lookup(col_phase_reg[dtg_pkg::PHASE_W-1 -: dtg_pkg::SINE_TABLE_BITS]);
        sine_sum = (dtg_pkg::SINE_W+1)'(row_sine) + (dtg_pkg::SINE_W+1)'(col_sine);
        product  = $signed({1'b0, amplitude}) * sine_sum;
        rounded  = product + 32'sd8192;
        scaled   = $signed(rounded[31:14]);
        if (scaled > 18'sd32767)
        begin
            clipped = 16'sh7FFF;
        end
        else if (scaled < -18'sd32768)
        begin
            clipped = 16'sh8000;
        end
        else
        begin
            clipped = scaled[15:0];
        end
        // both phases are zero on the first sample of a digit
        sample = ctrl.restart ? '0 : clipped;
    end

endmodule

// ----- design/dtmf_tone_generator_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// DTMF tone generator core
// Digit queue, playback sequencer and dual-tone synthesiser behind streams.
// ============================================================================
// Each request is either a symbol push (s_tuser low) or one sample tick
// (s_tuser high) and yields exactly one result: the audio sample, the tone
// flag, a drop flag for a push into a full queue, and the queue level. Every
// request is held in an input register, processed in a single pass (queue
// update, sequencer step, sine look-up and one 15x17 multiply) and captured
// in the result register, so one request per clock is sustained while
// m_tready stays high. m_tready feeds s_tready combinationally. The queue
// needs no clearing after reset. Configuration must be written through
// cfg_we/cfg_addr/cfg_wdata while no request is in flight; the block does not enforce it.
module dtmf_tone_generator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dtg_pkg::IN_TDATA_W-1:0]     s_tdata,   // [3:0] symbol, [7:4] zero
    input  logic                               s_tuser,   // [0] command
    // master stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dtg_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [15:0] sample, [16] tone_on,
                                                          // [17] dropped, [22:18] queue_level,
                                                          // [23] zero
    // configuration
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_addr,
    input  logic [dtg_pkg::CFG_W-1:0]          cfg_wdata
);

    // Configuration registers
    logic [dtg_pkg::AMP_W-1:0] amplitude_reg;
    logic [dtg_pkg::LEN_W-1:0] tone_len_reg;
    logic [dtg_pkg::LEN_W-1:0] pause_len_reg;

    // Input register
    logic                      in_valid_reg;
    logic                      in_cmd_reg;
    logic [dtg_pkg::SYM_W-1:0] in_sym_reg;
    logic                      advance;

    // Sequencer state
    dtg_pkg::play_mode_t       mode_reg;
    dtg_pkg::play_mode_t       mode_next;
    dtg_pkg::play_mode_t       mode_eff;
    logic [dtg_pkg::SYM_W-1:0] digit_reg;
    logic [dtg_pkg::LEN_W-1:0] tick_reg;
    logic [dtg_pkg::LEN_W-1:0] tick_next;
    logic [dtg_pkg::LEN_W-1:0] tick_inc;

    // Inter-module control
    dtg_pkg::queue_ctrl_t      q_ctrl;
    dtg_pkg::queue_stat_t      q_stat;
    logic [dtg_pkg::SYM_W-1:0] q_head;
    dtg_pkg::tone_ctrl_t       t_ctrl;
    logic signed [dtg_pkg::SAMPLE_W-1:0] tone_sample;

    logic                      is_tick;
    logic                      start;
    logic                      dropped;
    logic                      tone_on;
    logic [dtg_pkg::SAMPLE_W-1:0] sample_res;

    // Result register
    logic                      m_tvalid_reg;
    logic [dtg_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= dtg_pkg::AMPLITUDE_RST;
            tone_len_reg  <= dtg_pkg::TONE_RST;
            pause_len_reg <= dtg_pkg::PAUSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dtg_pkg::CFG_AMPLITUDE:     amplitude_reg <= cfg_wdata[dtg_pkg::AMP_W-1:0];
                dtg_pkg::CFG_TONE_SAMPLES:  tone_len_reg  <= cfg_wdata[dtg_pkg::LEN_W-1:0];
                dtg_pkg::CFG_PAUSE_SAMPLES: pause_len_reg <= cfg_wdata[dtg_pkg::LEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Handshake: the stage moves when the result register is free or draining
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg <= s_tuser;
            in_sym_reg <= s_tdata[dtg_pkg::SYM_W-1:0];
        end
    end

    // Request decode
    always_comb
    begin
        is_tick = (in_cmd_reg == dtg_pkg::CMD_TICK);
        start   = advance && is_tick && (mode_reg == dtg_pkg::MODE_IDLE) && !q_stat.empty;
        dropped = !is_tick && q_stat.full;

        q_ctrl.push   = advance && !is_tick && !q_stat.full;
        q_ctrl.pop    = start;
        q_ctrl.symbol = in_sym_reg;

        mode_eff = start ? dtg_pkg::MODE_TONE : mode_reg;
        tick_inc = (start ? '0 : tick_reg) + 1'b1;

        t_ctrl.run     = advance && is_tick && (mode_eff == dtg_pkg::MODE_TONE);
        t_ctrl.restart = start;
        t_ctrl.digit   = start ? q_head : digit_reg;
    end

    // Playback sequencer: tone for tone_len ticks, then pause_len silent ticks
    always_comb
    begin
        mode_next = mode_reg;
        tick_next = tick_reg;
        if (advance && is_tick)
        begin
            unique case (mode_eff)
                dtg_pkg::MODE_TONE:
                begin
                    mode_next = dtg_pkg::MODE_TONE;
                    tick_next = tick_inc;
                    if (tick_inc >= tone_len_reg || tick_inc == '0)
                    begin
                        tick_next = '0;
                        mode_next = (pause_len_reg == '0) ? dtg_pkg::MODE_IDLE
                                                          : dtg_pkg::MODE_PAUSE;
                    end
                end
                dtg_pkg::MODE_PAUSE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= pause_len_reg || tick_inc == '0)
                    begin
                        tick_next = '0;
                        mode_next = dtg_pkg::MODE_IDLE;
                    end
                end
                dtg_pkg::MODE_IDLE:
                begin
                    mode_next = dtg_pkg::MODE_IDLE;
                end
                default:
                begin
                    mode_next = dtg_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dtg_pkg::MODE_IDLE;
            tick_reg  <= '0;
            digit_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            tick_reg <= tick_next;
            if (start)
            begin
                digit_reg <= q_head;
            end
        end
    end

    dtg_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat),
        .head  (q_head)
    );

    dtg_tone u_tone
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (t_ctrl),
        .amplitude (amplitude_reg),
        .sample    (tone_sample)
    );

    // Result assembly
    always_comb
    begin
        tone_on    = (mode_next == dtg_pkg::MODE_TONE);
        sample_res = (is_tick && mode_eff == dtg_pkg::MODE_TONE) ? tone_sample : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {1'b0, q_stat.level_next, dropped, tone_on, sample_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
